[rtl/core/receiver_arm_switch_interlock_top_assert.svh]
// Assertion macros for the receiver arm switch interlock checker.
`ifndef RECEIVER_ARM_SWITCH_INTERLOCK_TOP_ASSERT_SVH
`define RECEIVER_ARM_SWITCH_INTERLOCK_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RASI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("interlock check failed");

// The consequent must hold in the cycle after the antecedent.
`define RASI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("interlock check failed");

`endif

[rtl/core/rasi_pkg.sv]
`timescale 1ns / 1ps

package rasi_pkg;

    localparam int THR_W      = 12;
    localparam int CNT_W      = 32;
    localparam int SRC_W      = 2;
    localparam int STATUS_W   = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [THR_W-1:0] THROTTLE_LIMIT_RESET = THR_W'(205);

    localparam logic REG_THROTTLE_LIMIT = 1'b0;

    localparam logic [SRC_W-1:0] SRC_NONE     = SRC_W'(0);
    localparam logic [SRC_W-1:0] SRC_RECEIVER = SRC_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        ST_UNAVAILABLE = 4'd0,
        ST_OTHER       = 4'd1,
        ST_WAIT_LOW    = 4'd2,
        ST_READY       = 4'd3,
        ST_ACTIVE      = 4'd4,
        ST_BLOCKED     = 4'd5,
        ST_ARMED       = 4'd6,
        ST_ARM_REJ     = 4'd7,
        ST_DISARMED    = 4'd8,
        ST_DISARM_REJ  = 4'd9
    } t_status;

    typedef struct packed {
        logic             snapshot_valid;
        logic [THR_W-1:0] throttle;
        logic             link_fresh;
        logic             failsafe_state_live;
        logic             failsafe_action_live;
        logic             arm_sw_up;
        logic [SRC_W-1:0] active_source;
        logic             arm_would_accept;
        logic             disarm_would_accept;
    } t_in_item;

    typedef struct packed {
        logic low_seen;
        logic prior_switch_high;
        logic switch_seen;
    } t_qual;

    typedef struct packed {
        logic [CNT_W-1:0] arm_attempts;
        logic [CNT_W-1:0] arm_refusals;
        logic [CNT_W-1:0] disarm_attempts;
    } t_counts;

    typedef struct packed {
        t_status status;
        logic    arm_request;
        logic    disarm_request;
        t_counts counts;
    } t_out_item;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
    endfunction

endpackage

[rtl/core/rasi_if.sv]
`timescale 1ns / 1ps

interface rasi_in_if
    import rasi_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             snapshot_valid;
    logic [THR_W-1:0] throttle;
    logic             link_fresh;
    logic             failsafe_state_live;
    logic             failsafe_action_live;
    logic             arm_sw_up;
    logic [SRC_W-1:0] active_source;
    logic             arm_would_accept;
    logic             disarm_would_accept;

    modport source (
        output valid, snapshot_valid, throttle, link_fresh, failsafe_state_live,
               failsafe_action_live, arm_sw_up, active_source,
               arm_would_accept, disarm_would_accept,
        input  ready
    );

    modport sink (
        input  valid, snapshot_valid, throttle, link_fresh, failsafe_state_live,
               failsafe_action_live, arm_sw_up, active_source,
               arm_would_accept, disarm_would_accept,
        output ready
    );
endinterface

interface rasi_out_if
    import rasi_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                arm_request;
    logic                disarm_request;
    logic [CNT_W-1:0]    arm_attempts;
    logic [CNT_W-1:0]    arm_refusals;
    logic [CNT_W-1:0]    disarm_attempts;

    modport source (
        output valid, status, arm_request, disarm_request, arm_attempts,
               arm_refusals, disarm_attempts,
        input  ready
    );

    modport sink (
        input  valid, status, arm_request, disarm_request, arm_attempts,
               arm_refusals, disarm_attempts,
        output ready
    );
endinterface

[rtl/core/rasi_decide.sv]
`timescale 1ns / 1ps

module rasi_decide
    import rasi_pkg::*;
(
    input  t_in_item         i_item,
    input  t_qual            i_qual,
    input  t_counts          i_counts,
    input  logic [THR_W-1:0] i_limit,
    output t_qual            o_qual,
    output t_out_item        o_result
);

    logic    usable;
    logic    rising;
    t_qual   n_qual;
    t_counts n_counts;
    t_status status;
    logic    arm_req;
    logic    disarm_req;

    assign usable = i_item.snapshot_valid & i_item.link_fresh &
                    i_item.failsafe_state_live & i_item.failsafe_action_live;
    assign rising = i_qual.switch_seen & ~i_qual.prior_switch_high;

    always_comb begin
        n_qual     = i_qual;
        n_counts   = i_counts;
        status     = ST_UNAVAILABLE;
        arm_req    = 1'b0;
        disarm_req = 1'b0;
        if (!usable) begin
            n_qual = '0;
            status = ST_UNAVAILABLE;
        end else if (i_item.active_source != SRC_NONE &&
                     i_item.active_source != SRC_RECEIVER) begin
            n_qual = '0;
            status = ST_OTHER;
        end else if (i_item.active_source == SRC_RECEIVER) begin
            n_qual.switch_seen       = 1'b1;
            n_qual.prior_switch_high = i_item.arm_sw_up;
            if (i_item.arm_sw_up) begin
                status = ST_ACTIVE;
            end else begin
                disarm_req               = 1'b1;
                n_counts.disarm_attempts = sat_inc(i_counts.disarm_attempts);
                if (i_item.disarm_would_accept) begin
                    n_qual.low_seen = 1'b1;
                    status          = ST_DISARMED;
                end else begin
                    status = ST_DISARM_REJ;
                end
            end
        end else if (!i_item.arm_sw_up) begin
            n_qual.low_seen          = 1'b1;
            n_qual.prior_switch_high = 1'b0;
            n_qual.switch_seen       = 1'b1;
            status                   = ST_READY;
        end else begin
            n_qual.prior_switch_high = 1'b1;
            n_qual.switch_seen       = 1'b1;
            if (!i_qual.low_seen || !rising) begin
                status = ST_WAIT_LOW;
            end else begin
                n_qual.low_seen       = 1'b0;
                n_counts.arm_attempts = sat_inc(i_counts.arm_attempts);
                if (i_item.throttle > i_limit) begin
                    n_counts.arm_refusals = sat_inc(i_counts.arm_refusals);
                    status                = ST_BLOCKED;
                end else begin
                    arm_req = 1'b1;
                    if (i_item.arm_would_accept) begin
                        status = ST_ARMED;
                    end else begin
                        n_counts.arm_refusals = sat_inc(i_counts.arm_refusals);
                        status                = ST_ARM_REJ;
                    end
                end
            end
        end
    end

    assign o_qual                  = n_qual;
    assign o_result.status         = status;
    assign o_result.arm_request    = arm_req;
    assign o_result.disarm_request = disarm_req;
    assign o_result.counts         = n_counts;

endmodule

[rtl/core/receiver_arm_switch_interlock_top.sv]
`timescale 1ns / 1ps

// Channel     Direction  Handshake          Payload
// i_item      in         valid / ready      one receiver snapshot
// o_result    out        valid / ready      status, request strobes, counters
// config      in         APB write / read   throttle_limit at byte address 0
//
// An item is registered on acceptance and decided from the input register into
// the result register once the result register is empty or being taken.
// One item is accepted every cycle while the result side keeps taking items.
// A stalled result holds in the result register while one more item waits in
// the input register; input ready drops only when both are full.
// Reset is synchronous and active low; it clears the flags, the counters and
// both valid bits, and sets throttle_limit to 205.

module receiver_arm_switch_interlock_top
    import rasi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rasi_in_if.sink               i_item,
    rasi_out_if.source            o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic             r_s1_valid;
    t_in_item         r_s1;
    logic             r_out_valid;
    t_out_item        r_out;
    t_qual            r_qual;
    t_counts          r_counts;
    logic [THR_W-1:0] r_limit;

    t_in_item         in_item;
    t_qual            n_qual;
    t_out_item        n_out;
    logic             advance;
    logic             in_fire;
    logic             cfg_write;
    logic             reg_sel;

    assign in_item.snapshot_valid       = i_item.snapshot_valid;
    assign in_item.throttle             = i_item.throttle;
    assign in_item.link_fresh           = i_item.link_fresh;
    assign in_item.failsafe_state_live  = i_item.failsafe_state_live;
    assign in_item.failsafe_action_live = i_item.failsafe_action_live;
    assign in_item.arm_sw_up            = i_item.arm_sw_up;
    assign in_item.active_source        = i_item.active_source;
    assign in_item.arm_would_accept     = i_item.arm_would_accept;
    assign in_item.disarm_would_accept  = i_item.disarm_would_accept;

    assign advance      = r_s1_valid & (~r_out_valid | o_result.ready);
    assign i_item.ready = ~r_s1_valid | advance;
    assign in_fire      = i_item.valid & i_item.ready;

    rasi_decide u_decide (
        .i_item   (r_s1),
        .i_qual   (r_qual),
        .i_counts (r_counts),
        .i_limit  (r_limit),
        .o_qual   (n_qual),
        .o_result (n_out)
    );

    assign reg_sel   = paddr[CFG_ADDR_W-1];
    assign cfg_write = psel & penable & pwrite & pready;
    assign pready    = 1'b1;
    assign prdata    = (reg_sel == REG_THROTTLE_LIMIT) ?
                       {{(CFG_DATA_W-THR_W){1'b0}}, r_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_qual      <= '0;
            r_counts    <= '0;
            r_limit     <= THROTTLE_LIMIT_RESET;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_qual      <= n_qual;
                r_counts    <= n_out.counts;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_write && reg_sel == REG_THROTTLE_LIMIT) begin
                r_limit <= pwdata[THR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.status          = r_out.status;
    assign o_result.arm_request     = r_out.arm_request;
    assign o_result.disarm_request  = r_out.disarm_request;
    assign o_result.arm_attempts    = r_out.counts.arm_attempts;
    assign o_result.arm_refusals    = r_out.counts.arm_refusals;
    assign o_result.disarm_attempts = r_out.counts.disarm_attempts;

endmodule

[rtl/core/rasi_checker.sv]
`timescale 1ns / 1ps
`include "receiver_arm_switch_interlock_top_assert.svh"

module rasi_checker
    import rasi_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic                i_arm_request,
    input logic                i_disarm_request,
    input logic [CNT_W-1:0]    i_arm_attempts,
    input logic [CNT_W-1:0]    i_arm_refusals
);

    `RASI_ASSERT_NOW(a_req_exclusive, i_clk, i_rst_n, i_out_valid, !(i_arm_request && i_disarm_request))

    `RASI_ASSERT_NOW(a_arm_status, i_clk, i_rst_n, i_out_valid && i_arm_request, i_status == ST_ARMED || i_status == ST_ARM_REJ)

    `RASI_ASSERT_NOW(a_refusal_bound, i_clk, i_rst_n, i_out_valid, i_arm_refusals <= i_arm_attempts)

    `RASI_ASSERT_NOW(a_attempts_grow, i_clk, i_rst_n, i_out_valid && $past(i_out_valid), i_arm_attempts >= $past(i_arm_attempts))

    `RASI_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status))

endmodule

bind receiver_arm_switch_interlock_top rasi_checker u_rasi_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_status         (o_result.status),
    .i_arm_request    (o_result.arm_request),
    .i_disarm_request (o_result.disarm_request),
    .i_arm_attempts   (o_result.arm_attempts),
    .i_arm_refusals   (o_result.arm_refusals)
);
